### hw/rtl/rect_polar_converter_defines.svh
// Assertion macros shared by the rectangular / polar converter RTL.
`ifndef RECT_POLAR_CONVERTER_DEFINES_SVH
`define RECT_POLAR_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rpc_pkg.sv
// Types, constants and the arctangent table of the rectangular / polar converter.
package rpc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 31;
  localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  // pre (2) + rotations + post (2)
  localparam int LATENCY       = NUM_STAGES + 4;

  // Datapath width: Q16.18 coordinates with headroom for CORDIC growth.
  localparam int DW = 38;
  localparam int ZW = 32;

  localparam logic [29:0]        INV_GAIN    = 30'd652032874;
  localparam logic signed [15:0] QUARTER_ANG = 16'sd16384;
  localparam logic [ZW-1:0]      HALF_TURN   = 32'h8000_0000;

  localparam logic CMD_RECT  = 1'b0;
  localparam logic CMD_POLAR = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } req_t;

  typedef struct packed {
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic [32:0] magnitude;
    logic [15:0] angle;
  } rsp_t;

  // Request data that rides alongside the rotation datapath.
  typedef struct packed {
    logic        cmd;
    logic        zero;
    logic [31:0] a;
    logic [31:0] b;
  } side_t;

  typedef struct packed {
    logic          valid;
    side_t         side;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [ZW-1:0] z;
  } cordic_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/rect_polar_converter.sv
// Top level of the rectangular / polar vector converter.
//
//  channel   ports                      handshake
//  --------  -------------------------  -----------------------------------
//  request   start, busy, request       taken when start && !busy
//  result    done, result               one-cycle strobe, cannot be held off
//
// One request enters per clock; busy stays low, as the pipeline never
// stalls. The path runs through two front-end stages (gain multiply, then
// rounding and quadrant fold), one register per CORDIC micro-rotation, and
// two back-end stages (split gain multiply, then sum, saturate and select).
// rst is synchronous and clears only the valid bits; requests in flight at
// reset are dropped.
`include "rect_polar_converter_defines.svh"

module rect_polar_converter (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rpc_pkg::req_t request,
  output logic          done,
  output rpc_pkg::rsp_t result
);

  logic             accept;
  rpc_pkg::cordic_t pre_out;
  rpc_pkg::cordic_t rot_out;

  // The pipeline advances every cycle, so the request side is never held.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Build the start vector: polar requests scale the magnitude by 1/K and
  // fold the angle into the right half plane; rectangular requests fold
  // x < 0 vectors by a half turn and flag the zero vector.
  rpc_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .req      (request),
    .cout     (pre_out)
  );

  // Shared rotation pipeline: vectoring for rectangular requests, rotation
  // for polar ones, chosen per item by the carried command bit.
  rpc_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .cin  (pre_out),
    .cout (rot_out)
  );

  // Compensate gain, round, saturate, and echo the given form.
  rpc_post u_post (
    .clk    (clk),
    .rst    (rst),
    .cin    (rot_out),
    .done   (done),
    .result (result)
  );

  // A computed magnitude is never negative; an echoed one is a sign extension.
  `RPC_ASSERT_IMP(a_mag_form, done,
                  !result.magnitude[32] || result.magnitude[31],
                  "magnitude bit 32 inconsistent")

  // Every result traces back to a request taken one full pipeline pass earlier.
  `RPC_ASSERT_IMP(a_latency, done, $past(start, rpc_pkg::LATENCY),
                  "result without matching request")

endmodule

### hw/rtl/rpc_pre.sv
// Front end: gain-scaled start vector, quadrant fold and zero detect.
module rpc_pre (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rpc_pkg::req_t   req,
  output rpc_pkg::cordic_t cout
);

  // Stage 1 registers
  logic                         v1;
  rpc_pkg::side_t               side1;
  logic signed [62:0]           prod1;
  logic [rpc_pkg::DW-1:0]       rx1;
  logic [rpc_pkg::DW-1:0]       ry1;
  logic [rpc_pkg::ZW-1:0]       rz1;
  logic                         flip1;
  logic [rpc_pkg::ZW-1:0]       pz1;

  // Stage 2 register
  rpc_pkg::cordic_t             c2;

  logic signed [62:0]           prod_c;
  logic [rpc_pkg::DW-1:0]       ax_c;
  logic [rpc_pkg::DW-1:0]       by_c;
  logic                         neg_c;
  logic signed [15:0]           ain_c;
  logic                         flip_c;

  logic signed [62:0]           rnd_c;
  logic [rpc_pkg::DW-1:0]       px_c;

  always_comb begin
    prod_c = $signed(req.first_value) * $signed({1'b0, rpc_pkg::INV_GAIN});
    ax_c   = {{(rpc_pkg::DW-34){req.first_value[31]}}, req.first_value, 2'b00};
    by_c   = {{(rpc_pkg::DW-34){req.second_value[31]}}, req.second_value, 2'b00};
    neg_c  = req.first_value[31];
    ain_c  = $signed(req.second_value[15:0]);
    flip_c = (ain_c > rpc_pkg::QUARTER_ANG) || (ain_c < -rpc_pkg::QUARTER_ANG);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    side1.cmd  <= req.command;
    side1.zero <= (req.command == rpc_pkg::CMD_RECT) &&
                  (req.first_value == '0) && (req.second_value == '0);
    side1.a    <= req.first_value;
    side1.b    <= req.second_value;
    prod1      <= prod_c;
    // fold a left-half vector into the right half, angle starts at a half turn
    rx1        <= neg_c ? (~ax_c + 1'b1) : ax_c;
    ry1        <= neg_c ? (~by_c + 1'b1) : by_c;
    rz1        <= neg_c ? rpc_pkg::HALF_TURN : '0;
    flip1      <= flip_c;
    pz1        <= {req.second_value[15:0], 16'h0000} ^ (flip_c ? rpc_pkg::HALF_TURN : '0);
  end

  always_comb begin
    rnd_c = prod1 + 63'sd134217728;
    px_c  = {{(rpc_pkg::DW-35){rnd_c[62]}}, rnd_c[62:28]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.valid <= 1'b0;
    end else begin
      c2.valid <= v1;
    end
    c2.side <= side1;
    if (side1.cmd == rpc_pkg::CMD_RECT) begin
      c2.x <= rx1;
      c2.y <= ry1;
      c2.z <= rz1;
    end else begin
      c2.x <= flip1 ? (~px_c + 1'b1) : px_c;
      c2.y <= '0;
      c2.z <= pz1;
    end
  end

  assign cout = c2;

endmodule

### hw/rtl/rpc_cordic.sv
// Unrolled CORDIC rotation pipeline, one micro-rotation per register stage.
`include "rect_polar_converter_defines.svh"

module rpc_cordic (
  input  logic             clk,
  input  logic             rst,
  input  rpc_pkg::cordic_t cin,
  output rpc_pkg::cordic_t cout
);

  rpc_pkg::cordic_t chain [rpc_pkg::NUM_STAGES+1];

  assign chain[0] = cin;

  for (genvar i = 0; i < rpc_pkg::NUM_STAGES; i++) begin : g_stage
    localparam logic [rpc_pkg::ZW-1:0] AT = rpc_pkg::atan_entry(5'(i));

    rpc_pkg::cordic_t             q;
    logic signed [rpc_pkg::DW-1:0] dx;
    logic signed [rpc_pkg::DW-1:0] dy;
    logic                         ccw;

    always_comb begin
      dx = $signed(chain[i].y) >>> i;
      dy = $signed(chain[i].x) >>> i;
      // vectoring drives y to zero, rotation drives z to zero
      ccw = (chain[i].side.cmd == rpc_pkg::CMD_RECT) ? chain[i].y[rpc_pkg::DW-1]
                                                      : !chain[i].z[rpc_pkg::ZW-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        q.valid <= 1'b0;
      end else begin
        q.valid <= chain[i].valid;
      end
      q.side <= chain[i].side;
      if (ccw) begin
        q.x <= chain[i].x - dx;
        q.y <= chain[i].y + dy;
        q.z <= chain[i].z - AT;
      end else begin
        q.x <= chain[i].x + dx;
        q.y <= chain[i].y - dy;
        q.z <= chain[i].z + AT;
      end
    end

    assign chain[i+1] = q;
  end

  assign cout = chain[rpc_pkg::NUM_STAGES];

  // Vectoring starts in the right half plane and only ever grows x.
  `RPC_ASSERT_IMP(a_rect_x_nonneg,
                  cout.valid && (cout.side.cmd == rpc_pkg::CMD_RECT),
                  !cout.x[rpc_pkg::DW-1],
                  "vectoring x went negative")

endmodule

### hw/rtl/rpc_post.sv
// Back end: gain compensation, rounding, saturation and result register.
module rpc_post (
  input  logic             clk,
  input  logic             rst,
  input  rpc_pkg::cordic_t cin,
  output logic             done,
  output rpc_pkg::rsp_t    result
);

  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] r;
    if (!v[36] && (v[35:31] != 5'b00000)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[36] && (v[35:31] != 5'b11111)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Stage 1 registers
  logic            v1;
  rpc_pkg::side_t  side1;
  logic [47:0]     lo1;
  logic [47:0]     hi1;
  logic [15:0]     ang1;
  logic [31:0]     xs1;
  logic [31:0]     ys1;

  logic signed [38:0] xr_c;
  logic signed [38:0] yr_c;
  logic [31:0]        zr_c;

  always_comb begin
    xr_c = $signed({cin.x[rpc_pkg::DW-1], cin.x}) + 39'sd2;
    yr_c = $signed({cin.y[rpc_pkg::DW-1], cin.y}) + 39'sd2;
    zr_c = cin.z + 32'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cin.valid;
    end
    side1 <= cin.side;
    // split the gain multiply into two 18 x 30 partial products
    lo1   <= 48'(cin.x[17:0]) * 48'(rpc_pkg::INV_GAIN);
    hi1   <= 48'(cin.x[35:18]) * 48'(rpc_pkg::INV_GAIN);
    ang1  <= zr_c[31:16];
    xs1   <= sat32(xr_c[38:2]);
    ys1   <= sat32(yr_c[38:2]);
  end

  logic [65:0] psum_c;
  logic [32:0] mag_c;

  always_comb begin
    psum_c = {hi1, 18'b0} + {18'b0, lo1} + 66'h0_8000_0000;
    mag_c  = (psum_c[65:64] != 2'b00) ? 33'h0_FFFF_FFFF : {1'b0, psum_c[63:32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    if (side1.cmd == rpc_pkg::CMD_RECT) begin
      result.x_coord   <= side1.a;
      result.y_coord   <= side1.b;
      result.magnitude <= side1.zero ? '0 : mag_c;
      result.angle     <= side1.zero ? '0 : ang1;
    end else begin
      result.x_coord   <= xs1;
      result.y_coord   <= ys1;
      result.magnitude <= {side1.a[31], side1.a};
      result.angle     <= side1.b[15:0];
    end
  end

endmodule

### bench/tb_top.sv
// Self-checking testbench for the CORDIC rectangular / polar vector converter.
module tb_top;

  // Allow this many cycles with no request taken and no result seen.
  localparam int IDLE_LIMIT = 2000;

  // Gain compensation, 1/K in Q30, and the quarter / half turn in 32-bit turns.
  localparam longint RECIP_GAIN = 64'sd652032874;
  localparam longint QUARTER    = 64'sd1073741824;
  localparam longint HALF       = 64'sd2147483648;

  // Arctangent of 2^-i, scaled so that 2^31 is a half turn.
  longint arctan_turns [0:30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1
  };

  // One row of the directed table; the typed result is used only if typed is set.
  typedef struct {
    logic        cmd;
    logic [31:0] first;
    logic [31:0] second;
    bit          typed;
    logic [31:0] want_x;
    logic [31:0] want_y;
    logic [32:0] want_mag;
    logic [15:0] want_ang;
  } stim_row_t;

  stim_row_t directed_rows [0:23] = '{
    // Zero vector: magnitude and angle are forced to 0.
    '{rpc_pkg::CMD_RECT,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    // Negative x on the axis: the angle lands on the half-turn wrap.
    '{rpc_pkg::CMD_RECT,  32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    // Longest vector the ports allow: checks the top of the magnitude range.
    '{rpc_pkg::CMD_RECT,  32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'hFFFF_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_RECT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    // Zero length in polar form gives the origin and echoes the inputs.
    '{rpc_pkg::CMD_POLAR, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_POLAR, 32'h0000_0000, 32'h0000_4000, 1'b1, 32'h0, 32'h0, 33'h0, 16'h4000},
    '{rpc_pkg::CMD_POLAR, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_POLAR, 32'h7FFF_FFFF, 32'h0000_4000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_POLAR, 32'h7FFF_FFFF, 32'h0000_8000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    // Most negative length: x runs past the top and must saturate.
    '{rpc_pkg::CMD_POLAR, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_POLAR, 32'h8000_0000, 32'h0000_8000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    // Just past a quarter turn either way triggers the quadrant fold; exactly -1/4 does not.
    '{rpc_pkg::CMD_POLAR, 32'h0001_0000, 32'h0000_4001, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_POLAR, 32'h0001_0000, 32'h0000_BFFF, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    '{rpc_pkg::CMD_POLAR, 32'h0001_0000, 32'h0000_C000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0},
    // Upper half of the angle word is junk in polar mode.
    '{rpc_pkg::CMD_POLAR, 32'h0001_0000, 32'hFFFF_2000, 1'b0, 32'h0, 32'h0, 33'h0, 16'h0}
  };

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  rpc_pkg::req_t  request = '0;
  logic           done;
  rpc_pkg::rsp_t  result;

  rpc_pkg::rsp_t  pending_results [$];
  int             error_count = 0;
  int             idle_cycles = 0;

  rect_polar_converter u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  // Bit-exact fixed-point CORDIC: returns both forms of the vector in a request.
  function automatic rpc_pkg::rsp_t convert_vector(rpc_pkg::req_t r);
    rpc_pkg::rsp_t   res;
    longint          xa, yb, x, y, z, dx, dy, turn;
    longint unsigned prod;
    int              i;
    xa = longint'(signed'(r.first_value));
    yb = longint'(signed'(r.second_value));
    if (r.command == rpc_pkg::CMD_RECT) begin
      res.x_coord = r.first_value;
      res.y_coord = r.second_value;
      if (xa == 0 && yb == 0) begin
        res.magnitude = '0;
        res.angle     = '0;
      end else begin
        // Go to Q16.18, fold the left half-plane onto the right.
        x = xa * 4;
        y = yb * 4;
        z = 0;
        if (x < 0) begin
          x = -x;
          y = -y;
          z = HALF;
        end
        // Vectoring: drive y to zero, accumulate the angle turned.
        for (i = 0; i < rpc_pkg::NUM_STAGES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx;
            y -= dy;
            z += arctan_turns[i];
          end else begin
            x -= dx;
            y += dy;
            z -= arctan_turns[i];
          end
        end
        // x is positive here; scale by 1/K and drop the Q30 and guard bits.
        prod = x;
        prod = (prod * 64'd652032874 + (64'd1 << 31)) >> 32;
        if (prod > 64'hFFFF_FFFF)
          prod = 64'hFFFF_FFFF;
        res.magnitude = prod[32:0];
        turn = (z + 32768) >>> 16;
        res.angle = turn[15:0];
      end
    end else begin
      z = longint'(signed'(r.second_value[15:0])) * 65536;
      x = (xa * RECIP_GAIN + (64'sd1 <<< 27)) >>> 28;
      y = 0;
      // Fold angles beyond a quarter turn by flipping the start vector.
      if (z > QUARTER) begin
        z -= HALF;
        x = -x;
      end else if (z < -QUARTER) begin
        z += HALF;
        x = -x;
      end
      // Rotation: drive z to zero.
      for (i = 0; i < rpc_pkg::NUM_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= arctan_turns[i];
        end else begin
          x += dx;
          y -= dy;
          z += arctan_turns[i];
        end
      end
      x = (x + 2) >>> 2;
      y = (y + 2) >>> 2;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      res.x_coord   = x[31:0];
      res.y_coord   = y[31:0];
      res.magnitude = {r.first_value[31], r.first_value};
      res.angle     = r.second_value[15:0];
    end
    return res;
  endfunction

  // Mix of full-range, small, shifted-down and edge coordinates.
  function automatic logic [31:0] pick_coord();
    logic [31:0] edges [0:7];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'h1, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001};
    case ($urandom_range(0, 5))
      0, 1:    return $urandom();
      2:       return 32'($urandom_range(0, 4000)) - 32'd2000;
      3:       return edges[$urandom_range(0, 7)];
      default: return 32'($signed($urandom()) >>> $urandom_range(1, 28));
    endcase
  endfunction

  // Angle word: random upper half, low half random or near a fold boundary, the wrap or zero.
  function automatic logic [31:0] pick_angle();
    logic [15:0] edges [0:7];
    logic [31:0] word;
    edges = '{16'h4000, 16'h4001, 16'hC000, 16'hBFFF,
              16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    word = $urandom();
    if ($urandom_range(0, 3) == 0)
      word[15:0] = edges[$urandom_range(0, 7)];
    return word;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold a request until it is taken, record what it must produce, then idle for the gap, if any.
  task automatic send_request(input rpc_pkg::req_t r, input bit typed,
                              input rpc_pkg::rsp_t typed_rsp, input int gap);
    bit stalled;
    start   <= 1'b1;
    request <= r;
    // sample busy on the falling edge, ahead of the rising edge that takes the request.
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
    if (typed)
      pending_results.push_back(typed_rsp);
    else
      pending_results.push_back(convert_vector(r));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: directed table first, then random requests.
  initial begin : drive_requests
    rpc_pkg::req_t r;
    rpc_pkg::rsp_t typed_rsp;
    int            k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[row]) begin
      r.command      = directed_rows[row].cmd;
      r.first_value  = directed_rows[row].first;
      r.second_value = directed_rows[row].second;
      typed_rsp = '{x_coord:   directed_rows[row].want_x,
                    y_coord:   directed_rows[row].want_y,
                    magnitude: directed_rows[row].want_mag,
                    angle:     directed_rows[row].want_ang};
      send_request(r, directed_rows[row].typed, typed_rsp, pick_gap());
    end

    for (k = 0; k < 700; k++) begin
      r.command      = $urandom_range(0, 1) ? rpc_pkg::CMD_POLAR : rpc_pkg::CMD_RECT;
      r.first_value  = pick_coord();
      r.second_value = (r.command == rpc_pkg::CMD_POLAR) ? pick_angle() : pick_coord();
      // Run every fourth block of 25 requests at full rate.
      send_request(r, 1'b0, '0, ((k / 25) % 4 == 3) ? 0 : pick_gap());
    end
    start <= 1'b0;

    // Drain the pipeline, then give stray results a chance to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (rpc_pkg::LATENCY + 8) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Compare each result strobe against the oldest outstanding request.
  always @(posedge clk) begin : check_results
    rpc_pkg::rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.x_coord !== want.x_coord) begin
          $error("x_coord: expected %h, got %h", want.x_coord, result.x_coord);
          error_count++;
        end
        if (result.y_coord !== want.y_coord) begin
          $error("y_coord: expected %h, got %h", want.y_coord, result.y_coord);
          error_count++;
        end
        if (result.magnitude !== want.magnitude) begin
          $error("magnitude: expected %h, got %h", want.magnitude, result.magnitude);
          error_count++;
        end
        if (result.angle !== want.angle) begin
          $error("angle: expected %h, got %h", want.angle, result.angle);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no request taken and no result seen for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_pre.sv
hw/rtl/rpc_cordic.sv
hw/rtl/rpc_post.sv
hw/rtl/rect_polar_converter.sv
bench/tb_top.sv
